[rtl/miv_pkg.sv]
// Shared types and constants of the 3x3 matrix inverse pipeline.
package miv_pkg;

  localparam int unsigned IN_W         = 16;  // Q8.8 entry
  localparam int unsigned OUT_W        = 32;  // Q16.16 entry
  localparam int unsigned PROD_W       = 32;  // 16x16 product
  localparam int unsigned CF_W         = 33;  // signed cofactor
  localparam int unsigned DP_W         = 49;  // entry times cofactor
  localparam int unsigned DET_W        = 51;  // sum of three terms
  localparam int unsigned NUM_W        = 56;  // |cofactor| << 24
  localparam int unsigned DEN_W        = 49;  // |det|
  localparam int unsigned Q_W          = 33;  // quotient bits kept
  localparam int unsigned R_W          = DEN_W + Q_W;
  localparam int unsigned EPS_W        = 24;
  localparam int unsigned FRAC_SHIFT   = 24;
  localparam int unsigned DIV_STAGES   = Q_W;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;
  localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;
  localparam logic [OUT_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG   = 32'h8000_0000;

  typedef struct packed {
    logic signed [IN_W-1:0] a00;
    logic signed [IN_W-1:0] a01;
    logic signed [IN_W-1:0] a02;
    logic signed [IN_W-1:0] a10;
    logic signed [IN_W-1:0] a11;
    logic signed [IN_W-1:0] a12;
    logic signed [IN_W-1:0] a20;
    logic signed [IN_W-1:0] a21;
    logic signed [IN_W-1:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv00;
    logic signed [OUT_W-1:0] inv01;
    logic signed [OUT_W-1:0] inv02;
    logic signed [OUT_W-1:0] inv10;
    logic signed [OUT_W-1:0] inv11;
    logic signed [OUT_W-1:0] inv12;
    logic signed [OUT_W-1:0] inv20;
    logic signed [OUT_W-1:0] inv21;
    logic signed [OUT_W-1:0] inv22;
    logic                    singular;
  } inv_t;

  // Work handed from the cofactor front end to one divider lane
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             sat;
    logic             zero;
  } lane_in_t;

endpackage

[rtl/miv_front.sv]
// Cofactor, determinant and singularity front end of the inverse pipeline.
module miv_front (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  miv_pkg::mat_t                    mat_i,
  input  logic [miv_pkg::EPS_W-1:0]        eps_i,
  output miv_pkg::lane_in_t [8:0]          lane_o
);

  logic signed [miv_pkg::IN_W-1:0]   m [9];
  logic signed [miv_pkg::PROD_W-1:0] pa_d [9];
  logic signed [miv_pkg::PROD_W-1:0] pb_d [9];
  logic signed [miv_pkg::PROD_W-1:0] pa_q [9];
  logic signed [miv_pkg::PROD_W-1:0] pb_q [9];
  logic signed [miv_pkg::IN_W-1:0]   m0a_q [3];
  logic signed [miv_pkg::IN_W-1:0]   m0b_q [3];
  logic signed [miv_pkg::CF_W-1:0]   cb_q [9];
  logic signed [miv_pkg::CF_W-1:0]   cc_q [9];
  logic signed [miv_pkg::DP_W-1:0]   dp_q [3];
  logic signed [miv_pkg::DET_W-1:0]  det;
  logic [miv_pkg::DEN_W-1:0]         den;
  logic                              zero;
  miv_pkg::lane_in_t [8:0]           lane_d;
  miv_pkg::lane_in_t [8:0]           lane_q;

  assign m[0] = mat_i.a00;
  assign m[1] = mat_i.a01;
  assign m[2] = mat_i.a02;
  assign m[3] = mat_i.a10;
  assign m[4] = mat_i.a11;
  assign m[5] = mat_i.a12;
  assign m[6] = mat_i.a20;
  assign m[7] = mat_i.a21;
  assign m[8] = mat_i.a22;

  // Form the two products of each 2x2 cofactor from the cyclic minors
  always_comb begin
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        pa_d[i*3+j] = m[i1*3+j1] * m[i2*3+j2];
        pb_d[i*3+j] = m[i1*3+j2] * m[i2*3+j1];
      end
    end
  end

  // Sum the determinant and prepare each lane's numerator, sign and range check
  always_comb begin
    logic signed [miv_pkg::CF_W-1:0] adj;
    logic [miv_pkg::CF_W-1:0]        mag;
    logic [miv_pkg::NUM_W-1:0]       num;
    det  = miv_pkg::DET_W'(dp_q[0]) + miv_pkg::DET_W'(dp_q[1]) + miv_pkg::DET_W'(dp_q[2]);
    den  = det[miv_pkg::DET_W-1] ? miv_pkg::DEN_W'(-det) : det[miv_pkg::DEN_W-1:0];
    zero = (det == '0) || (den < miv_pkg::DEN_W'(eps_i));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj = cc_q[j*3+i];
        mag = adj[miv_pkg::CF_W-1] ? -adj : adj;
        num = {mag[miv_pkg::OUT_W-1:0], miv_pkg::FRAC_SHIFT'(0)};
        lane_d[i*3+j].num  = num;
        lane_d[i*3+j].den  = den;
        lane_d[i*3+j].neg  = adj[miv_pkg::CF_W-1] ^ det[miv_pkg::DET_W-1];
        lane_d[i*3+j].sat  = miv_pkg::DEN_W'(num >> miv_pkg::Q_W) >= den;
        lane_d[i*3+j].zero = zero;
      end
    end
  end

  // Advance the four front stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= pa_d[k];
        pb_q[k] <= pb_d[k];
        cb_q[k] <= miv_pkg::CF_W'(pa_q[k]) - miv_pkg::CF_W'(pb_q[k]);
        cc_q[k] <= cb_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        m0a_q[k] <= m[k];
        m0b_q[k] <= m0a_q[k];
        dp_q[k]  <= m0b_q[k] * cb_q[k];
      end
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[rtl/miv_div_lane.sv]
// One restoring divider lane, one quotient bit per stage, with saturation.
module miv_div_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  miv_pkg::lane_in_t             lane_i,
  output logic [miv_pkg::OUT_W-1:0]     res_o,
  output logic                          zero_o
);

  localparam int unsigned NS = miv_pkg::DIV_STAGES;

  logic [miv_pkg::R_W-1:0]   r_q [NS];
  logic [miv_pkg::R_W-1:0]   r_d [NS];
  logic [miv_pkg::Q_W-1:0]   q_q [NS];
  logic [miv_pkg::Q_W-1:0]   q_d [NS];
  logic [miv_pkg::DEN_W-1:0] d_q [NS];
  logic [miv_pkg::DEN_W-1:0] d_s [NS];
  logic                      neg_q [NS];
  logic                      sat_q [NS];
  logic                      zr_q [NS];
  logic                      neg_s [NS];
  logic                      sat_s [NS];
  logic                      zr_s [NS];
  logic [miv_pkg::OUT_W-1:0] res_d;
  logic [miv_pkg::OUT_W-1:0] res_q;
  logic                      zero_q;

  // Trial subtract of the shifted divisor at each stage
  always_comb begin
    logic [miv_pkg::R_W-1:0] r;
    logic [miv_pkg::R_W-1:0] dsh;
    logic [miv_pkg::Q_W-1:0] q;
    logic                    ge;
    for (int s = 0; s < NS; s++) begin
      r      = (s == 0) ? miv_pkg::R_W'(lane_i.num) : r_q[(s == 0) ? 0 : s-1];
      q      = (s == 0) ? '0 : q_q[(s == 0) ? 0 : s-1];
      d_s[s] = (s == 0) ? lane_i.den : d_q[(s == 0) ? 0 : s-1];
      neg_s[s] = (s == 0) ? lane_i.neg : neg_q[(s == 0) ? 0 : s-1];
      sat_s[s] = (s == 0) ? lane_i.sat : sat_q[(s == 0) ? 0 : s-1];
      zr_s[s]  = (s == 0) ? lane_i.zero : zr_q[(s == 0) ? 0 : s-1];
      dsh    = miv_pkg::R_W'(d_s[s]) << (NS - 1 - s);
      ge     = r >= dsh;
      r_d[s] = ge ? r - dsh : r;
      q_d[s] = {q[miv_pkg::Q_W-2:0], ge};
    end
  end

  // Clamp the final quotient and apply the sign; a singular lane gives zero
  always_comb begin
    logic [miv_pkg::Q_W-1:0] qf;
    qf = q_q[NS-1];
    if (zr_q[NS-1]) begin
      res_d = '0;
    end else if (neg_q[NS-1]) begin
      res_d = (sat_q[NS-1] || qf[miv_pkg::Q_W-1] || qf[miv_pkg::OUT_W-1]) ?
              miv_pkg::SAT_NEG : miv_pkg::OUT_W'(-qf);
    end else begin
      res_d = (sat_q[NS-1] || qf[miv_pkg::Q_W-1] || qf[miv_pkg::OUT_W-1]) ?
              miv_pkg::SAT_POS : qf[miv_pkg::OUT_W-1:0];
    end
  end

  // Advance all divider stages and the result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        r_q[s]   <= r_d[s];
        q_q[s]   <= q_d[s];
        d_q[s]   <= d_s[s];
        neg_q[s] <= neg_s[s];
        sat_q[s] <= sat_s[s];
        zr_q[s]  <= zr_s[s];
      end
      res_q  <= res_d;
      zero_q <= zr_q[NS-1];
    end
  end

  assign res_o  = res_q;
  assign zero_o = zero_q;

endmodule

[rtl/matrix_inverse_3x3.sv]
// Top level of the pipelined 3x3 matrix inverse.
// Usage:
//   in channel:  in_valid_i / in_ready_o carry one matrix of nine signed Q8.8
//                entries per transfer (mat_t).
//   out channel: out_valid_o / out_ready_i carry the nine signed Q16.16
//                inverse entries and the singular flag (inv_t).
//   cfg channel: cfg_valid_i / cfg_ready_o write det_epsilon (24 bits, units
//                of 2^-24); always ready. Write only while the pipe is empty.
// From input transfer to output valid a matrix passes four front stages
// (products, cofactors, determinant terms, determinant sum), 33 divider
// stages that resolve one quotient bit each, and one saturation register.
// Nine divider lanes run side by side, one per inverse entry.
// Throughput is one matrix per cycle unless stalled. The whole pipe advances
// as one: when the receiver stalls with a result waiting, in_ready_o drops and
// every stage holds; bubbles in the pipe do not stall it.
// Reset clears all valid bits and loads det_epsilon with 168.
// A determinant of zero or with magnitude below det_epsilon sets singular and
// zeroes all nine entries.
module matrix_inverse_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  miv_pkg::mat_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output miv_pkg::inv_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [miv_pkg::EPS_W-1:0]     cfg_data_i
);

  localparam int unsigned PD = miv_pkg::PIPE_DEPTH;

  logic                         en;
  logic [PD-1:0]                v_q;
  logic [miv_pkg::EPS_W-1:0]    eps_q;
  miv_pkg::lane_in_t [8:0]      lane;
  logic [miv_pkg::OUT_W-1:0]    res [9];
  logic [8:0]                   zr;

  assign en          = !v_q[PD-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = v_q[PD-1];

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= miv_pkg::EPS_RESET;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PD-2:0], in_valid_i};
    end
  end

  miv_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .mat_i  (in_data_i),
    .eps_i  (eps_q),
    .lane_o (lane)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    miv_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane[k]),
      .res_o  (res[k]),
      .zero_o (zr[k])
    );
  end

  // Merge the lane results into one transfer
  assign out_data_o.inv00    = res[0];
  assign out_data_o.inv01    = res[1];
  assign out_data_o.inv02    = res[2];
  assign out_data_o.inv10    = res[3];
  assign out_data_o.inv11    = res[4];
  assign out_data_o.inv12    = res[5];
  assign out_data_o.inv20    = res[6];
  assign out_data_o.inv21    = res[7];
  assign out_data_o.inv22    = res[8];
  assign out_data_o.singular = zr[0];

  // A singular result carries all-zero entries
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (out_data_o[$bits(miv_pkg::inv_t)-1:1] == '0))
    else $error("singular result with nonzero entries");

  // All lanes agree on the singular decision
  a_lane_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zr == '0 || zr == '1))
    else $error("lanes disagree on singular flag");

  // A stalled result holds through the pipe stall
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

[bench/testbench.sv]
// Self-checking bench for the pipelined 3x3 matrix inverse with a scoreboard class.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LATENCY    = 38;
  localparam int unsigned WATCHDOG   = 4000;
  localparam int unsigned N_RANDOM   = 1550;

  // Compute expected inverse entries and compare with the block's results
  class inv_scoreboard;
    miv_pkg::inv_t pending[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  singular_seen;
    logic [miv_pkg::EPS_W-1:0] eps;

    function new();
      errors = 0;
      checked = 0;
      singular_seen = 0;
      eps = miv_pkg::EPS_RESET;
    endfunction

    function logic [miv_pkg::OUT_W-1:0] quotient(longint adj, longint det);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] q;
      bit          neg;
      n = (adj < 0) ? -adj : adj;
      n = n << miv_pkg::FRAC_SHIFT;
      d = (det < 0) ? -det : det;
      q = n / d;
      neg = (adj < 0) != (det < 0);
      if (neg) begin
        if (q >= 64'h8000_0000) return miv_pkg::SAT_NEG;
        return -q[miv_pkg::OUT_W-1:0];
      end
      if (q > 64'h7FFF_FFFF) return miv_pkg::SAT_POS;
      return q[miv_pkg::OUT_W-1:0];
    endfunction

    function void note_matrix(miv_pkg::mat_t a);
      longint m[3][3];
      longint c[3][3];
      longint det;
      logic [63:0] mag;
      miv_pkg::inv_t r;
      m[0][0] = a.a00; m[0][1] = a.a01; m[0][2] = a.a02;
      m[1][0] = a.a10; m[1][1] = a.a11; m[1][2] = a.a12;
      m[2][0] = a.a20; m[2][1] = a.a21; m[2][2] = a.a22;
      c[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
      c[0][1] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
      c[0][2] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
      c[1][0] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
      c[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
      c[1][2] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
      c[2][0] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
      c[2][1] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
      c[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
      det = m[0][0] * c[0][0] + m[0][1] * c[0][1] + m[0][2] * c[0][2];
      mag = (det < 0) ? -det : det;
      r = '0;
      if (det == 0 || mag < {40'd0, eps}) begin
        r.singular = 1'b1;
      end else begin
        // Transposed cofactors over the determinant
        r.inv00 = quotient(c[0][0], det);
        r.inv01 = quotient(c[1][0], det);
        r.inv02 = quotient(c[2][0], det);
        r.inv10 = quotient(c[0][1], det);
        r.inv11 = quotient(c[1][1], det);
        r.inv12 = quotient(c[2][1], det);
        r.inv20 = quotient(c[0][2], det);
        r.inv21 = quotient(c[1][2], det);
        r.inv22 = quotient(c[2][2], det);
      end
      pending.push_back(r);
    endfunction

    function void check_result(miv_pkg::inv_t got);
      miv_pkg::inv_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.singular) singular_seen++;
      if (got.inv00 !== want.inv00) report("inv00", want.inv00, got.inv00);
      if (got.inv01 !== want.inv01) report("inv01", want.inv01, got.inv01);
      if (got.inv02 !== want.inv02) report("inv02", want.inv02, got.inv02);
      if (got.inv10 !== want.inv10) report("inv10", want.inv10, got.inv10);
      if (got.inv11 !== want.inv11) report("inv11", want.inv11, got.inv11);
      if (got.inv12 !== want.inv12) report("inv12", want.inv12, got.inv12);
      if (got.inv20 !== want.inv20) report("inv20", want.inv20, got.inv20);
      if (got.inv21 !== want.inv21) report("inv21", want.inv21, got.inv21);
      if (got.inv22 !== want.inv22) report("inv22", want.inv22, got.inv22);
      if (got.singular !== want.singular)
        report("singular", want.singular, got.singular);
    endfunction

    function void report(string field, logic [miv_pkg::OUT_W-1:0] want,
                         logic [miv_pkg::OUT_W-1:0] got);
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      errors++;
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  miv_pkg::mat_t             in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  miv_pkg::inv_t             out_data_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [miv_pkg::EPS_W-1:0] cfg_data_i;

  inv_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  bit            long_hold;
  int unsigned   quiet_cycles;
  int unsigned   sent;

  matrix_inverse_3x3 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Drive receiver ready at the falling edge
  always @(negedge clk_i) begin
    if (long_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || long_hold) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one matrix and hold it until the transfer
  task automatic send_matrix(miv_pkg::mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_matrix(m);
    sent++;
    @(negedge clk_i);
  endtask

  // Drain the pipe, then write the threshold
  task automatic write_epsilon(logic [miv_pkg::EPS_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.eps = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [miv_pkg::IN_W-1:0] pick_entry();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0100;
      4: return 16'hFF00;
      5, 6: return miv_pkg::IN_W'($urandom_range(1023) - 512);
      default: return miv_pkg::IN_W'($urandom());
    endcase
  endfunction

  function automatic miv_pkg::mat_t random_matrix();
    miv_pkg::mat_t m;
    case ($urandom_range(9))
      // Rank deficient: third row copies the first
      0: begin
        m = '0;
        m.a00 = pick_entry(); m.a01 = pick_entry(); m.a02 = pick_entry();
        m.a10 = pick_entry(); m.a11 = pick_entry(); m.a12 = pick_entry();
        m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end
      // Tiny diagonal: determinant near the threshold
      1: begin
        m = '0;
        m.a00 = miv_pkg::IN_W'($urandom_range(8));
        m.a11 = miv_pkg::IN_W'($urandom_range(8));
        m.a22 = miv_pkg::IN_W'($urandom_range(8));
        if ($urandom_range(1)) m.a01 = miv_pkg::IN_W'($urandom_range(3));
      end
      default: begin
        m.a00 = pick_entry(); m.a01 = pick_entry(); m.a02 = pick_entry();
        m.a10 = pick_entry(); m.a11 = pick_entry(); m.a12 = pick_entry();
        m.a20 = pick_entry(); m.a21 = pick_entry(); m.a22 = pick_entry();
      end
    endcase
    return m;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_matrix(random_matrix());
  endtask

  // Receiver holds off for a long stretch while matrices keep coming
  initial begin : hold_off
    wait (sent >= 200);
    @(negedge clk_i);
    long_hold = 1'b1;
    repeat (150) @(negedge clk_i);
    long_hold = 1'b0;
  end

  initial begin : stimulus
    miv_pkg::mat_t m;
    int unsigned drain;
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: identity, diagonal, extremes, singular, saturation
    m = '0; m.a00 = 16'h0100; m.a11 = 16'h0100; m.a22 = 16'h0100;
    send_matrix(m);
    m = '0; m.a00 = 16'hFF00; m.a11 = 16'h0200; m.a22 = 16'h0080;
    send_matrix(m);
    send_matrix('0);
    send_matrix({9{16'h7FFF}});
    send_matrix({9{16'h8000}});
    m = '0; m.a00 = 16'h8000; m.a11 = 16'h8000; m.a22 = 16'h8000;
    send_matrix(m);
    m = '0; m.a00 = 16'h7FFF; m.a11 = 16'h7FFF; m.a22 = 16'h7FFF;
    send_matrix(m);
    m = '0; m.a00 = 16'h0001; m.a11 = 16'h0001; m.a22 = 16'h0001;
    send_matrix(m);
    m = '0; m.a00 = 16'h0006; m.a11 = 16'h0006; m.a22 = 16'h0006;
    send_matrix(m);
    m = '0; m.a00 = 16'h0001; m.a11 = 16'h0100; m.a22 = 16'h0100;
    m.a01 = 16'h8000;
    send_matrix(m);
    m = {16'h0001, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF,
         16'h8000, 16'h7FFF, 16'hFFFF};
    send_matrix(m);

    // Zero threshold: exact zero still singular
    write_epsilon('0);
    send_matrix('0);
    m = '0; m.a00 = 16'h0001; m.a11 = 16'h0001; m.a22 = 16'h0001;
    send_matrix(m);
    m = {16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300,
         16'h0001, 16'h0002, 16'h0005};
    send_matrix(m);
    random_phase(300, 0, 0);

    write_epsilon(24'hFFFFFF);
    m = '0; m.a00 = 16'h0100; m.a11 = 16'h0100; m.a22 = 16'h0100;
    send_matrix(m);
    m = '0; m.a00 = 16'h0400; m.a11 = 16'h0100; m.a22 = 16'h0100;
    send_matrix(m);
    random_phase(300, 47, 0);

    write_epsilon(miv_pkg::EPS_RESET);
    random_phase(350, 0, 47);

    write_epsilon(24'd1);
    random_phase(300, 30, 30);

    write_epsilon(miv_pkg::EPS_W'($urandom_range(24'hFFFFFF)));
    random_phase(300, 0, 0);

    in_valid_i <= 1'b0;
    drain = 0;
    while (sb.pending.size() != 0 && drain < 100000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (LATENCY + 4) @(negedge clk_i);
    $display("Sent %0d matrices over five threshold settings, %0d results checked",
             sent, sb.checked);
    $display("%0d singular results, idle and stall mixes incl. a long output hold",
             sb.singular_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[files.f]
rtl/miv_pkg.sv
rtl/miv_front.sv
rtl/miv_div_lane.sv
rtl/matrix_inverse_3x3.sv
bench/testbench.sv
